// File: rtl/qwm_pkg.sv
// shared types, constants and helpers for the two-stack max queue
`default_nettype none

package qwm_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int COUNT_WIDTH = 7;

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_POP_PUSH = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_XFER_RD,
        ST_XFER_WR,
        ST_POP_RD,
        ST_POP_DATA,
        ST_PUSH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        op_t                           opcode;
        logic signed [DATA_WIDTH-1:0]  value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  popped_value;
        logic signed [DATA_WIDTH-1:0]  window_max;
        logic                          max_valid;
        logic                          pop_error;
        logic                          push_overflow;
        logic [COUNT_WIDTH-1:0]        item_count;
    } rsp_word_t;

    // stack entry: max of everything below it, and the word itself
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  below_max;
        logic signed [DATA_WIDTH-1:0]  value;
    } entry_t;

    function automatic logic signed [DATA_WIDTH-1:0] word_max(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        return (a >= b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/queue_with_max_two_stacks.sv
// top level: fifo of signed words with running maximum, built from two stacks
`default_nettype none

// usage
//   cmd channel (cmd_valid / cmd_ready / cmd) takes one word per operation:
//   push, pop, pop-then-push (window slide) or no-op. rsp channel
//   (rsp_valid / rsp_ready / rsp) returns one word per operation with the
//   popped word, the maximum of what is held afterwards, the count and the
//   error flags.
//   one operation is handled at a time; cmd_ready is high only while idle.
//   a small sequencer steps through the two stack rams and one shared signed
//   compare unit, in order: check, then for a pop a front read and its data,
//   then for a push a back-stack write, then the result step. when a pop
//   finds the front stack empty, every back-stack word is first moved across
//   (one ram read and one ram write per moved word).
//   cmd_ready returns in the cycle rsp_valid rises; each word crosses stacks
//   at most once.
//   rsp is held in an output register: a new word may be accepted while a
//   result waits, and the sequencer waits in its last step until the
//   output register is free.
//   reset empties both stacks at once (depth counters only, ram content is
//   left as is) and drops rsp_valid.
module queue_with_max_two_stacks #(
    parameter int CAPACITY = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire qwm_pkg::cmd_word_t cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output qwm_pkg::rsp_word_t      rsp
);

    localparam int DW   = qwm_pkg::DATA_WIDTH;
    localparam int CW   = $clog2(CAPACITY + 1);   // depth counters hold CAPACITY
    localparam int AW   = $clog2(CAPACITY);
    localparam int EW   = $bits(qwm_pkg::entry_t);
    localparam int CNTW = (CW > qwm_pkg::COUNT_WIDTH) ? CW : qwm_pkg::COUNT_WIDTH;

    // sequencer and datapath registers
    qwm_pkg::state_t        state_reg, state_next;
    qwm_pkg::op_t           op_reg, op_next;
    logic signed [DW-1:0]   value_reg, value_next;
    logic [CW-1:0]          back_depth_reg, back_depth_next;
    logic [CW-1:0]          front_depth_reg, front_depth_next;
    // running max of each whole stack, meaningful while that stack is nonempty
    logic signed [DW-1:0]   back_top_reg, back_top_next;
    logic signed [DW-1:0]   front_top_reg, front_top_next;
    logic signed [DW-1:0]   popped_reg, popped_next;
    logic                   pop_err_reg, pop_err_next;
    logic                   push_ovf_reg, push_ovf_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    qwm_pkg::rsp_word_t     rsp_reg, rsp_next;

    // ram ports
    logic                   back_we, front_we;
    logic [AW-1:0]          back_waddr, back_raddr, front_waddr, front_raddr;
    qwm_pkg::entry_t        back_wdata, front_wdata;
    qwm_pkg::entry_t        back_rdata, front_rdata;

    // shared compare unit
    logic signed [DW-1:0]   cmp_a, cmp_b, cmp_max;

    logic [CW-1:0]          total;
    logic [CW-1:0]          back_dec, front_dec;
    logic [CNTW-1:0]        count_ext;
    logic                   do_pop, do_push;
    logic                   cmd_fire, rsp_free;
    logic                   queue_full;

    assign total      = back_depth_reg + front_depth_reg;
    assign back_dec   = back_depth_reg - CW'(1);
    assign front_dec  = front_depth_reg - CW'(1);
    assign count_ext  = CNTW'(total);
    assign queue_full = (total >= CW'(CAPACITY));

    assign do_pop  = (op_reg == qwm_pkg::OP_POP) || (op_reg == qwm_pkg::OP_POP_PUSH);
    assign do_push = (op_reg == qwm_pkg::OP_PUSH) || (op_reg == qwm_pkg::OP_POP_PUSH);

    assign cmd_fire = cmd_valid && cmd_ready;
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    assign cmp_max = qwm_pkg::word_max(cmp_a, cmp_b);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // back stack: pushes land here
    qwm_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

    // front stack: pops come from here, refilled from the back stack
    qwm_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_front_ram (
        .clk   (clk),
        .we    (front_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .raddr (front_raddr),
        .rdata (front_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qwm_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = qwm_pkg::ST_CHECK;
                end
            end
            qwm_pkg::ST_CHECK:
            begin
                priority if (do_pop && front_depth_reg != '0)
                begin
                    state_next = qwm_pkg::ST_POP_RD;
                end
                else if (do_pop && back_depth_reg != '0)
                begin
                    state_next = qwm_pkg::ST_XFER_RD;
                end
                else if (do_push)
                begin
                    state_next = qwm_pkg::ST_PUSH;
                end
                else
                begin
                    state_next = qwm_pkg::ST_RESULT;
                end
            end
            qwm_pkg::ST_XFER_RD:
            begin
                state_next = qwm_pkg::ST_XFER_WR;
            end
            qwm_pkg::ST_XFER_WR:
            begin
                // last word moved: front now holds the oldest word on top
                if (back_depth_reg == CW'(1))
                begin
                    state_next = qwm_pkg::ST_POP_RD;
                end
                else
                begin
                    state_next = qwm_pkg::ST_XFER_RD;
                end
            end
            qwm_pkg::ST_POP_RD:
            begin
                state_next = qwm_pkg::ST_POP_DATA;
            end
            qwm_pkg::ST_POP_DATA:
            begin
                state_next = do_push ? qwm_pkg::ST_PUSH : qwm_pkg::ST_RESULT;
            end
            qwm_pkg::ST_PUSH:
            begin
                state_next = qwm_pkg::ST_RESULT;
            end
            qwm_pkg::ST_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = qwm_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs: handshake, ram controls, compare operands
    always_comb
    begin
        cmd_ready   = 1'b0;
        back_we     = 1'b0;
        front_we    = 1'b0;
        back_waddr  = back_depth_reg[AW-1:0];
        back_raddr  = back_dec[AW-1:0];
        front_waddr = front_depth_reg[AW-1:0];
        front_raddr = front_dec[AW-1:0];
        back_wdata  = '{below_max: back_top_reg, value: value_reg};
        front_wdata = '{below_max: front_top_reg, value: back_rdata.value};
        cmp_a       = back_top_reg;
        cmp_b       = front_top_reg;
        unique case (state_reg)
            qwm_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            qwm_pkg::ST_XFER_WR:
            begin
                front_we = 1'b1;
                cmp_a    = back_rdata.value;
                cmp_b    = front_top_reg;
            end
            qwm_pkg::ST_PUSH:
            begin
                back_we = !queue_full;
                cmp_a   = value_reg;
                cmp_b   = back_top_reg;
            end
            qwm_pkg::ST_CHECK,
            qwm_pkg::ST_XFER_RD,
            qwm_pkg::ST_POP_RD,
            qwm_pkg::ST_POP_DATA,
            qwm_pkg::ST_RESULT:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        op_next          = op_reg;
        value_next       = value_reg;
        back_depth_next  = back_depth_reg;
        front_depth_next = front_depth_reg;
        back_top_next    = back_top_reg;
        front_top_next   = front_top_reg;
        popped_next      = popped_reg;
        pop_err_next     = pop_err_reg;
        push_ovf_next    = push_ovf_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;
        unique case (state_reg)
            qwm_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next       = cmd.opcode;
                    value_next    = cmd.value;
                    popped_next   = '0;
                    pop_err_next  = 1'b0;
                    push_ovf_next = 1'b0;
                end
            end
            qwm_pkg::ST_CHECK:
            begin
                // pop on an empty queue is flagged, a following push still runs
                if (do_pop && total == '0)
                begin
                    pop_err_next = 1'b1;
                end
            end
            qwm_pkg::ST_XFER_WR:
            begin
                front_depth_next = front_depth_reg + CW'(1);
                back_depth_next  = back_dec;
                front_top_next   = (front_depth_reg == '0) ? back_rdata.value : cmp_max;
            end
            qwm_pkg::ST_POP_DATA:
            begin
                popped_next      = front_rdata.value;
                front_top_next   = front_rdata.below_max;
                front_depth_next = front_dec;
            end
            qwm_pkg::ST_PUSH:
            begin
                if (queue_full)
                begin
                    push_ovf_next = 1'b1;
                end
                else
                begin
                    back_depth_next = back_depth_reg + CW'(1);
                    back_top_next   = (back_depth_reg == '0) ? value_reg : cmp_max;
                end
            end
            qwm_pkg::ST_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.popped_value  = popped_reg;
                    rsp_next.max_valid     = (total != '0);
                    rsp_next.pop_error     = pop_err_reg;
                    rsp_next.push_overflow = push_ovf_reg;
                    rsp_next.item_count    = count_ext[qwm_pkg::COUNT_WIDTH-1:0];
                    priority if (back_depth_reg != '0 && front_depth_reg != '0)
                    begin
                        rsp_next.window_max = cmp_max;
                    end
                    else if (back_depth_reg != '0)
                    begin
                        rsp_next.window_max = back_top_reg;
                    end
                    else if (front_depth_reg != '0)
                    begin
                        rsp_next.window_max = front_top_reg;
                    end
                    else
                    begin
                        rsp_next.window_max = '0;
                    end
                end
            end
            qwm_pkg::ST_XFER_RD,
            qwm_pkg::ST_POP_RD:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= qwm_pkg::ST_IDLE;
            back_depth_reg  <= '0;
            front_depth_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            back_depth_reg  <= back_depth_next;
            front_depth_reg <= front_depth_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        value_reg     <= value_next;
        back_top_reg  <= back_top_next;
        front_top_reg <= front_top_next;
        popped_reg    <= popped_next;
        pop_err_reg   <= pop_err_next;
        push_ovf_reg  <= push_ovf_next;
        rsp_reg       <= rsp_next;
    end

endmodule

`default_nettype wire

// File: rtl/qwm_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module qwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/qwm_checker.sv
// port-level checks for the two-stack max queue, bound to the top level
`default_nettype none

module qwm_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire qwm_pkg::rsp_word_t rsp
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // one operation at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("cmd accepted back to back");

    // max_valid follows the count
    a_max_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.max_valid == (rsp.item_count != '0)))
        else $error("max_valid disagrees with item_count");

    // failed pop returns zero
    a_pop_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.pop_error |-> rsp.popped_value == '0)
        else $error("popped_value nonzero on pop_error");

    // empty queue reports zero max
    a_empty_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.max_valid |-> rsp.window_max == '0)
        else $error("window_max nonzero on empty queue");

endmodule

bind queue_with_max_two_stacks qwm_checker u_qwm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
